// ===== hw/rtl/quadrature_step_decoder_unit_macros.svh =====
// Assertion macros for the quadrature step decoder unit.
`ifndef QUADRATURE_STEP_DECODER_UNIT_MACROS_SVH
`define QUADRATURE_STEP_DECODER_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define QSDU_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define QSDU_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/qsd_pkg.sv =====
// Shared types, constants and tables for the quadrature step decoder.
package qsd_pkg;

  localparam int TIME_WIDTH = 32;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd1000;
  localparam logic [2:0]  DETENT_RESET   = 3'd2;

  // Register indexes on the configuration port
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_DETENT   = 1'b1;

  typedef enum logic [2:0] {
    OUT_PRIMED    = 3'd0,
    OUT_NO_CHANGE = 3'd1,
    OUT_DEBOUNCED = 3'd2,
    OUT_JUMP      = 3'd3,
    OUT_STEP      = 3'd4
  } qsd_outcome_t;

  localparam logic signed [1:0] DETENT_NONE = 2'sd0;
  localparam logic signed [1:0] DETENT_CW   = 2'sd1;
  localparam logic signed [1:0] DETENT_CCW  = -2'sd1;

  typedef struct packed {
    logic        level_a;
    logic        level_b;
    logic [31:0] time_us;
  } qsd_in_t;

  typedef struct packed {
    logic signed [1:0] detent;
    logic [2:0]        outcome;
  } qsd_out_t;

  typedef struct packed {
    logic                  primed;
    logic [1:0]            last_phase;
    logic [TIME_WIDTH-1:0] change_time;
    logic [2:0]            cw_steps;
    logic [2:0]            ccw_steps;
  } qsd_state_t;

  // Next phase going clockwise in the gray order 00-01-11-10
  function automatic logic [1:0] cw_next(input logic [1:0] ph);
    logic [1:0] nx;
    case (ph)
      2'b00:   nx = 2'b01;
      2'b01:   nx = 2'b11;
      2'b11:   nx = 2'b10;
      default: nx = 2'b00;
    endcase
    return nx;
  endfunction

  // Next phase going counterclockwise
  function automatic logic [1:0] ccw_next(input logic [1:0] ph);
    logic [1:0] nx;
    case (ph)
      2'b00:   nx = 2'b10;
      2'b10:   nx = 2'b11;
      2'b11:   nx = 2'b01;
      default: nx = 2'b00;
    endcase
    return nx;
  endfunction

endpackage

// ===== hw/rtl/qsd_step.sv =====
// Combinational step logic: one sample against the stored decoder state.
module qsd_step import qsd_pkg::*; (
  input  qsd_in_t     item,
  input  qsd_state_t  cur,
  input  logic [15:0] debounce_time_us,
  input  logic [2:0]  steps_per_detent,
  output qsd_state_t  nxt,
  output qsd_out_t    res
);

  logic [1:0]            phase;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  too_early;
  logic                  is_cw;
  logic                  is_ccw;
  logic [2:0]            cw_inc;
  logic [2:0]            ccw_inc;

  assign phase     = {item.level_a, item.level_b};
  assign now       = TIME_WIDTH'(item.time_us);
  assign elapsed   = now - cur.change_time;
  assign too_early = elapsed < TIME_WIDTH'(debounce_time_us);
  assign is_cw     = cw_next(cur.last_phase) == phase;
  assign is_ccw    = ccw_next(cur.last_phase) == phase;
  assign cw_inc    = cur.cw_steps + 3'd1;
  assign ccw_inc   = cur.ccw_steps + 3'd1;

  // Decide the outcome and the next state
  always_comb begin
    nxt         = cur;
    res.detent  = DETENT_NONE;
    res.outcome = OUT_NO_CHANGE;
    if (!cur.primed) begin
      nxt.primed      = 1'b1;
      nxt.last_phase  = phase;
      nxt.change_time = now;
      nxt.cw_steps    = 3'd0;
      nxt.ccw_steps   = 3'd0;
      res.outcome     = OUT_PRIMED;
    end else if (phase == cur.last_phase) begin
      res.outcome = OUT_NO_CHANGE;
    end else if (too_early) begin
      res.outcome = OUT_DEBOUNCED;
    end else begin
      nxt.last_phase  = phase;
      nxt.change_time = now;
      if (is_cw) begin
        nxt.ccw_steps = 3'd0;
        res.outcome   = OUT_STEP;
        if (cw_inc >= steps_per_detent) begin
          nxt.cw_steps = 3'd0;
          res.detent   = DETENT_CW;
        end else begin
          nxt.cw_steps = cw_inc;
        end
      end else if (is_ccw) begin
        nxt.cw_steps = 3'd0;
        res.outcome  = OUT_STEP;
        if (ccw_inc >= steps_per_detent) begin
          nxt.ccw_steps = 3'd0;
          res.detent    = DETENT_CCW;
        end else begin
          nxt.ccw_steps = ccw_inc;
        end
      end else begin
        res.outcome = OUT_JUMP;
      end
    end
  end

endmodule

// ===== hw/rtl/quadrature_step_decoder_unit.sv =====
// Quadrature step decoder: input register, single-pass step logic, result register.
// An accepted request waits in the input register, then its result in the result register.
// Throughput: one request per cycle while out_ready is high; input frees as results load.
// The stored phase and counters feed back from the step logic, so one update per cycle.
// Reset (rst_n low, synchronous): empties both registers, unprimes the decoder,
// and loads debounce 1000 us and 2 steps per detent.
module quadrature_step_decoder_unit import qsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // sample channel
  input  logic        in_valid,
  output logic        in_ready,
  input  qsd_in_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output qsd_out_t    out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "quadrature_step_decoder_unit_macros.svh"

  logic        in_valid_r;
  qsd_in_t     in_data_r;
  logic        out_valid_r;
  qsd_out_t    out_data_r;
  qsd_state_t  state_r;
  qsd_state_t  state_nxt;
  qsd_out_t    res_nxt;
  logic [15:0] debounce_r;
  logic [2:0]  detent_steps_r;
  logic        advance;
  logic        cfg_write;
  logic        reg_sel;

  // Move a held request on when the result register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Hold the input request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  qsd_step u_step (
    .item             (in_data_r),
    .cur              (state_r),
    .debounce_time_us (debounce_r),
    .steps_per_detent (detent_steps_r),
    .nxt              (state_nxt),
    .res              (res_nxt)
  );

  // Advance the decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Load and drain the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Decode configuration writes
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= DEBOUNCE_RESET;
      detent_steps_r <= DETENT_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_DEBOUNCE: debounce_r     <= pwdata[15:0];
        REG_DETENT:   detent_steps_r <= pwdata[2:0];
        default:      ;
      endcase
    end
  end

  // Return the selected register
  always_comb begin
    unique case (reg_sel)
      REG_DEBOUNCE: prdata = {16'd0, debounce_r};
      REG_DETENT:   prdata = {29'd0, detent_steps_r};
      default:      prdata = '0;
    endcase
  end

  // Checks
  `QSDU_ASSERT_NOW(a_counters_exclusive, state_r.cw_steps != 3'd0, state_r.ccw_steps == 3'd0, "both step counters nonzero")
  `QSDU_ASSERT_NOW(a_detent_on_step, out_valid_r && out_data_r.detent != DETENT_NONE, out_data_r.outcome == OUT_STEP, "detent without counted step")
  `QSDU_ASSERT_NEXT(a_primed_sticks, state_r.primed, state_r.primed, "primed dropped without reset")
  `QSDU_ASSERT_NEXT(a_advance_loads, advance, out_valid_r, "result register not loaded")

endmodule

// ===== tb/sv/quadrature_step_decoder_unit_tb.sv =====
// Self-checking testbench for the quadrature step decoder unit.
module quadrature_step_decoder_unit_tb import qsd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PER_SETTING = 75;

  // Tracks decoder state from accepted samples and checks the decoder's answers
  class step_scoreboard;
    logic        primed;
    logic [1:0]  last_phase;
    logic [31:0] change_time;
    logic [2:0]  cw_count;
    logic [2:0]  ccw_count;
    logic [15:0] debounce;
    logic [2:0]  threshold;
    qsd_out_t    expected_results[$];
    int          mismatches;
    int          checked;
    int          outcome_seen[5];
    int          cw_detents;
    int          ccw_detents;

    function new();
      primed = 1'b0;
      last_phase = 2'b00;
      change_time = '0;
      cw_count = '0;
      ccw_count = '0;
      debounce = DEBOUNCE_RESET;
      threshold = DETENT_RESET;
      mismatches = 0;
      checked = 0;
      cw_detents = 0;
      ccw_detents = 0;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
    endfunction

    // Position of a phase along the clockwise gray sequence 00-01-11-10
    function logic [1:0] gray_pos(input logic [1:0] ph);
      return {ph[1], ph[1] ^ ph[0]};
    endfunction

    function void set_register(input logic idx, input logic [31:0] value);
      if (idx == REG_DEBOUNCE) debounce = value[15:0];
      else threshold = value[2:0];
    endfunction

    // Advance the predicted state by one accepted sample and queue its result
    function void note_sample(input qsd_in_t s);
      logic [1:0]  phase;
      logic [1:0]  delta;
      logic [31:0] elapsed;
      qsd_out_t    res;
      phase = {s.level_a, s.level_b};
      elapsed = s.time_us - change_time;
      res.detent = DETENT_NONE;
      if (!primed) begin
        primed = 1'b1;
        last_phase = phase;
        change_time = s.time_us;
        cw_count = '0;
        ccw_count = '0;
        res.outcome = OUT_PRIMED;
      end else if (phase == last_phase) begin
        res.outcome = OUT_NO_CHANGE;
      end else if (elapsed < {16'd0, debounce}) begin
        res.outcome = OUT_DEBOUNCED;
      end else begin
        delta = gray_pos(phase) - gray_pos(last_phase);
        if (delta == 2'd1) begin
          cw_count = cw_count + 3'd1;
          ccw_count = '0;
          if (cw_count >= threshold) begin
            cw_count = '0;
            res.detent = DETENT_CW;
          end
          res.outcome = OUT_STEP;
        end else if (delta == 2'd3) begin
          ccw_count = ccw_count + 3'd1;
          cw_count = '0;
          if (ccw_count >= threshold) begin
            ccw_count = '0;
            res.detent = DETENT_CCW;
          end
          res.outcome = OUT_STEP;
        end else begin
          res.outcome = OUT_JUMP;
        end
        last_phase = phase;
        change_time = s.time_us;
      end
      outcome_seen[res.outcome]++;
      if (res.detent == DETENT_CW) cw_detents++;
      if (res.detent == DETENT_CCW) ccw_detents++;
      expected_results.push_back(res);
    endfunction

    // Compare one delivered result with the oldest pending one
    function void check_result(input qsd_out_t got);
      qsd_out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result detent=%0d outcome=%0d", $time, got.detent,
                 got.outcome);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.detent !== want.detent) begin
        $display("%0t: detent mismatch, expected %0d, actual %0d", $time, want.detent,
                 got.detent);
        mismatches++;
      end
      if (got.outcome !== want.outcome) begin
        $display("%0t: outcome mismatch, expected %0d, actual %0d", $time, want.outcome,
                 got.outcome);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  qsd_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  qsd_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  step_scoreboard sb = new();
  logic no_stall = 1'b0;
  logic cw_run = 1'b1;
  int   stall_left = 0;
  int   idle_run = 0;
  int   settings_used = 1;
  int   sent = 0;

  quadrature_step_decoder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stall the result side in short random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!no_stall && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 4);
    end
  end

  // Check delivered results and count cycles without any handshake
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
  end

  initial begin
    wait (idle_run >= WATCHDOG_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Hold one sample request until accepted, then note it
  task automatic send_sample(input logic [1:0] ph, input logic [31:0] t);
    qsd_in_t s;
    s.level_a = ph[1];
    s.level_b = ph[0];
    s.time_us = t;
    if (!no_stall && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
    sent++;
  endtask

  // Send a phase a given time after the last accepted change
  task automatic send_after(input logic [1:0] ph, input logic [31:0] dt);
    send_sample(ph, sb.change_time + dt);
  endtask

  // Drop valid and wait until every pending result is delivered
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write a register over the APB port, then read it back
  task automatic write_register(input logic idx, input logic [31:0] value);
    logic [31:0] masked;
    masked = (idx == REG_DEBOUNCE) ? {16'd0, value[15:0]} : {29'd0, value[2:0]};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_register(idx, value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== masked) begin
      $display("%0t: register %0d readback, expected %0h, actual %0h", $time, idx,
               masked, prdata);
      sb.mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Load both registers; upper data bits are junk the port must drop
  task automatic configure(input logic [15:0] deb, input logic [2:0] thr);
    write_register(REG_DEBOUNCE, {16'($urandom), deb});
    write_register(REG_DETENT, {29'($urandom), thr});
    settings_used++;
  endtask

  function automatic logic [1:0] gray_step(input logic [1:0] ph, input logic cw);
    logic [1:0] pos;
    pos = sb.gray_pos(ph) + (cw ? 2'd1 : 2'd3);
    return {pos[1], pos[1] ^ pos[0]};
  endfunction

  // Mostly clean rotation with random timing, plus bounce, jumps and noise
  task automatic random_sample();
    int          kind;
    logic [15:0] deb;
    logic [31:0] dt;
    deb = sb.debounce;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 5) == 0) cw_run = ~cw_run;
    if (kind < 55) begin
      dt = ($urandom_range(0, 9) == 0) ? deb + $urandom_range(0, 1 << 20)
                                       : deb + $urandom_range(0, 40);
      send_after(gray_step(sb.last_phase, cw_run), dt);
    end else if (kind < 65) begin
      send_after(sb.last_phase, $urandom);
    end else if (kind < 77) begin
      dt = (deb == 0) ? 32'd0 : $urandom_range(0, deb - 1);
      send_after(gray_step(sb.last_phase, 1'($urandom_range(0, 1))), dt);
    end else if (kind < 85) begin
      send_after(~sb.last_phase, deb + $urandom_range(0, 40));
    end else begin
      send_sample(2'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [15:0] deb_set[8];
    logic [2:0]  thr_set[8];
    deb_set = '{16'd1000, 16'd0, 16'd65535, 16'd0, 16'd3, 16'd0, 16'd250, 16'd1000};
    thr_set = '{3'd2, 3'd1, 3'd7, 3'd0, 3'd5, 3'd0, 3'd4, 3'd3};
    deb_set[5] = 16'($urandom);
    thr_set[5] = 3'($urandom);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: prime, idle, step across the time wrap, bounce, detents
    send_sample(2'b11, 32'hFFFF_FF00);
    send_sample(2'b11, 32'h0000_0000);
    send_sample(2'b10, 32'h0000_02E8);
    send_after(2'b00, 32'd999);
    send_after(2'b00, 32'd1000);
    send_after(2'b11, 32'd1000);
    send_after(2'b01, 32'd1000);
    send_after(2'b00, 32'd1000);
    send_after(2'b01, 32'd1000);
    send_after(2'b00, 32'd1000);
    send_after(2'b01, 32'd1000);
    send_after(2'b11, 32'd1000);
    drain_results();

    // No debounce and a zero threshold: every step is a detent
    configure(16'd0, 3'd0);
    send_after(2'b10, 32'd0);
    send_after(2'b11, 32'd0);
    send_after(2'b00, 32'd0);
    send_sample(2'b00, 32'hFFFF_FFFF);
    drain_results();

    // Longest debounce and a threshold of seven
    configure(16'hFFFF, 3'd7);
    send_after(2'b01, 32'd65534);
    send_after(2'b01, 32'd65535);
    send_after(2'b11, 32'd65535);
    send_after(2'b10, 32'd65535);
    send_after(2'b00, 32'd65535);
    send_after(2'b01, 32'd65535);
    send_after(2'b11, 32'd65535);
    send_after(2'b10, 32'd65535);
    drain_results();

    // Random traffic under each setting; the fourth and the last run without stalls
    for (int p = 0; p < 8; p++) begin
      configure(deb_set[p], thr_set[p]);
      no_stall = (p == 3) || (p == 7);
      for (int i = 0; i < RANDOM_PER_SETTING; i++) random_sample();
      drain_results();
    end

    $display("Sent %0d samples under %0d register settings, %0d results checked.",
             sent, settings_used, sb.checked);
    $display("Outcomes primed/idle/bounce/jump/step: %0d/%0d/%0d/%0d/%0d, detents cw %0d ccw %0d",
             sb.outcome_seen[0], sb.outcome_seen[1], sb.outcome_seen[2],
             sb.outcome_seen[3], sb.outcome_seen[4], sb.cw_detents, sb.ccw_detents);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
